/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cts_pkg.sv */
// Package with the types, constants and register codes of the cache tag store.
`timescale 1ns / 1ps

package cts_pkg;

  localparam int DW = 32;
  localparam int TW = 30;
  localparam int SW = 32;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int DEF_WAYS       = 4;

  localparam logic [1:0] REG_ORG  = 2'd0;
  localparam logic [1:0] REG_REPL = 2'd1;
  localparam logic [1:0] REG_OFF  = 2'd2;
  localparam logic [1:0] REG_LOG  = 2'd3;

  localparam logic [1:0] ORG_DIRECT = 2'd0;
  localparam logic [1:0] ORG_SET    = 2'd1;
  localparam logic       REPL_FIFO  = 1'b0;

  localparam logic [3:0] OFF_MIN   = 4'd2;
  localparam logic [3:0] OFF_MAX   = 4'd12;
  localparam logic [3:0] OFF_RESET = 4'd4;
  localparam logic [3:0] LOG_MIN   = 4'd2;
  localparam logic [3:0] LOG_RESET = 4'd10;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [DW-1:0] rem;
  } div_res_t;

  typedef struct packed {
    logic          valid;
    logic [TW-1:0] tag;
    logic [SW-1:0] stamp;
  } entry_t;

endpackage

/* rtl/core/cts_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cts_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cts_div import cts_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output div_res_t      res_o
);

  localparam int CNTW = $clog2(DW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   quot_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {rem_q, quot_q[DW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = !diff[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DW-2:0], ge};
      rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

/* rtl/core/cache_tag_store_replacement.sv */
// Top level of the cache tag store with FIFO or LRU replacement.
//
//   channel  | signals                                  | moves
//   ---------+------------------------------------------+----------------------
//   input    | in_valid_i, in_ready_o, address_i        | one access request
//   output   | out_valid_o, out_ready_i, hit_o,         | one result per request
//            | evicted_o, evicted_tag_o                 |
//   config   | psel, penable, pwrite, paddr, pwdata,    | register access
//            | prdata, pready                           |
//
// A request runs two divider passes for the set split, a scan over the ways of its set
// in the tag store through its single read port, one more divider pass on a FIFO
// eviction, and the control states around them.
// After reset a clearing pass over all MAX_BLOCKS entries runs before any request is taken.
// A result waiting at the output holds the next request in its final step.
`timescale 1ns / 1ps

module cache_tag_store_replacement import cts_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int WAYS       = DEF_WAYS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [31:0]   address_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          hit_o,
  output logic          evicted_o,
  output logic [TW-1:0] evicted_tag_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int AW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW      = $clog2(MAX_BLOCKS + 1);
  localparam int FD      = MAX_BLOCKS / 2;
  localparam int FAW     = (FD > 1) ? $clog2(FD) : 1;
  localparam int LOG_MAX = CW - 1;
  localparam int EW      = $bits(entry_t);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_D1   = 4'd3;
  localparam logic [3:0] S_D2   = 4'd4;
  localparam logic [3:0] S_BASE = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_D3   = 4'd8;
  localparam logic [3:0] S_EVRD = 4'd9;
  localparam logic [3:0] S_WB   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [1:0] org_q;
  logic       repl_q;
  logic [3:0] off_q;
  logic [3:0] log_q;
  logic       cfg_we;

  logic [3:0]    state_q;
  logic [CW-1:0] clr_q;
  logic [DW-1:0] blk_q;
  logic [CW-1:0] blocks_q;
  logic [CW-1:0] ways_q;
  logic [TW-1:0] tag_q;
  logic [CW-1:0] set_q;
  logic [AW-1:0] base_q;
  logic [FAW-1:0] pidx_q;
  logic [CW-1:0] cnt_q;
  logic          rv_q;
  logic [CW-1:0] ridx_q;
  logic          hitf_q;
  logic [AW-1:0] hidx_q;
  logic          invf_q;
  logic [AW-1:0] iidx_q;
  logic [SW-1:0] min_q;
  logic [AW-1:0] midx_q;
  logic [AW-1:0] vict_q;
  logic          ev_q;
  logic [TW-1:0] evtag_q;
  logic [SW-1:0] stamp_q;
  logic          out_valid_q;
  logic          hit_q;
  logic          evo_q;
  logic [TW-1:0] evto_q;

  logic [3:0]    off_c;
  logic [4:0]    lb;
  logic [CW-1:0] blocks_c;
  logic [CW-1:0] ways_c;

  logic          div_start;
  logic [DW-1:0] div_num;
  logic [DW-1:0] div_den;
  div_res_t      div_res;

  logic          tm_we;
  logic [AW-1:0] tm_waddr;
  logic [EW-1:0] tm_wdata;
  logic          tm_re;
  logic [AW-1:0] tm_raddr;
  logic [EW-1:0] tm_rdata;
  entry_t        rd_e;
  entry_t        wr_e;

  logic           fm_we;
  logic [FAW-1:0] fm_waddr;
  logic [AW-1:0]  fm_wdata;
  logic           fm_re;
  logic [FAW-1:0] fm_raddr;
  logic [AW-1:0]  fm_rdata;

  logic           out_load;
  logic           fifo_pick;
  logic [CW-1:0]  vinc;
  logic [FAW-1:0] pidx_c;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q  <= ORG_DIRECT;
      repl_q <= REPL_FIFO;
      off_q  <= OFF_RESET;
      log_q  <= LOG_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_ORG:  org_q  <= pwdata[1:0];
        REG_REPL: repl_q <= pwdata[0];
        REG_OFF:  off_q  <= pwdata[3:0];
        REG_LOG:  log_q  <= pwdata[3:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ORG:  prdata = {30'd0, org_q};
      REG_REPL: prdata = {31'd0, repl_q};
      REG_OFF:  prdata = {28'd0, off_q};
      REG_LOG:  prdata = {28'd0, log_q};
      default:  prdata = '0;
    endcase
  end

  // Layout derived from the configuration.
  always_comb begin
    off_c = off_q;
    if (off_q < OFF_MIN) off_c = OFF_MIN;
    if (off_q > OFF_MAX) off_c = OFF_MAX;
    lb = {1'b0, log_q};
    if (log_q < LOG_MIN) lb = {1'b0, LOG_MIN};
    if (int'(lb) > LOG_MAX) lb = 5'(LOG_MAX);
    blocks_c = CW'(1) << lb;
    if (org_q == ORG_DIRECT) begin
      ways_c = CW'(1);
    end else if (org_q == ORG_SET) begin
      ways_c = (WAYS > int'(blocks_c)) ? blocks_c : CW'(WAYS);
    end else begin
      ways_c = blocks_c;
    end
  end

  // Shared divider: sets, then set and tag, then the FIFO victim.
  assign fifo_pick = (state_q == S_DEC) && !hitf_q && !invf_q && (ways_q != CW'(1))
                     && (repl_q == REPL_FIFO);
  assign div_start = (state_q == S_PREP) || ((state_q == S_D1) && div_res.done)
                     || fifo_pick;

  always_comb begin
    case (state_q)
      S_PREP: begin
        div_num = DW'(blocks_q);
        div_den = DW'(ways_q);
      end
      S_D1: begin
        div_num = blk_q;
        div_den = div_res.quot;
      end
      default: begin
        div_num = DW'(fm_rdata);
        div_den = DW'(ways_q);
      end
    endcase
  end

  cts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .res_o   (div_res)
  );

  // Tag store: valid bit, tag and use stamp of each entry.
  assign rd_e = entry_t'(tm_rdata);

  always_comb begin
    wr_e.valid = 1'b1;
    wr_e.tag   = tag_q;
    wr_e.stamp = stamp_q;
    tm_we      = 1'b0;
    tm_waddr   = AW'(base_q + vict_q);
    tm_wdata   = wr_e;
    tm_re      = 1'b0;
    tm_raddr   = AW'(base_q + cnt_q[AW-1:0]);
    if (state_q == S_CLR) begin
      tm_we    = 1'b1;
      tm_waddr = clr_q[AW-1:0];
      tm_wdata = '0;
    end else if (state_q == S_WB) begin
      tm_we = 1'b1;
    end
    if ((state_q == S_SCAN) && (cnt_q < ways_q)) begin
      tm_re = 1'b1;
    end else if (state_q == S_EVRD) begin
      tm_re    = 1'b1;
      tm_raddr = AW'(base_q + vict_q);
    end
  end

  cts_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tm_we),
    .waddr_i (tm_waddr),
    .wdata_i (tm_wdata),
    .re_i    (tm_re),
    .raddr_i (tm_raddr),
    .rdata_o (tm_rdata)
  );

  // FIFO pointers, one per set.
  assign vinc   = div_res.rem[CW-1:0] + CW'(1);
  assign pidx_c = ((org_q == ORG_SET) && (int'(set_q) < FD)) ? set_q[FAW-1:0] : '0;

  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = pidx_q;
    fm_wdata = (vinc == ways_q) ? '0 : vinc[AW-1:0];
    if ((state_q == S_CLR) && (int'(clr_q) < FD)) begin
      fm_we    = 1'b1;
      fm_waddr = clr_q[FAW-1:0];
      fm_wdata = '0;
    end else if ((state_q == S_D3) && div_res.done) begin
      fm_we = 1'b1;
    end
  end

  assign fm_re    = (state_q == S_BASE);
  assign fm_raddr = pidx_c;

  cts_ram #(.WIDTH(AW), .DEPTH(FD)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fm_we),
    .waddr_i (fm_waddr),
    .wdata_i (fm_wdata),
    .re_i    (fm_re),
    .raddr_i (fm_raddr),
    .rdata_o (fm_rdata)
  );

  // Sequencer.
  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
    end else begin
      rv_q <= tm_re && (state_q == S_SCAN);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == CW'(MAX_BLOCKS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_PREP;
        end
        S_PREP: state_q <= S_D1;
        S_D1: begin
          if (div_res.done) state_q <= S_D2;
        end
        S_D2: begin
          if (div_res.done) state_q <= S_BASE;
        end
        S_BASE: begin
          cnt_q   <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (tm_re) cnt_q <= cnt_q + CW'(1);
          if (rv_q && (ridx_q == ways_q - CW'(1))) state_q <= S_DEC;
        end
        S_DEC: state_q <= fifo_pick ? S_D3 : S_EVRD;
        S_D3: begin
          if (div_res.done) state_q <= S_EVRD;
        end
        S_EVRD: state_q <= S_WB;
        S_WB: begin
          stamp_q <= stamp_q + SW'(1);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= cnt_q;
    case (state_q)
      S_IDLE: begin
        blk_q    <= address_i >> off_c;
        blocks_q <= blocks_c;
        ways_q   <= ways_c;
      end
      S_D2: begin
        if (div_res.done) begin
          tag_q <= div_res.quot[TW-1:0];
          set_q <= div_res.rem[CW-1:0];
        end
      end
      S_BASE: begin
        base_q <= AW'(set_q * ways_q);
        pidx_q <= pidx_c;
        hitf_q <= 1'b0;
        invf_q <= 1'b0;
      end
      S_SCAN: begin
        if (rv_q) begin
          if (rd_e.valid && (rd_e.tag == tag_q) && !hitf_q) begin
            hitf_q <= 1'b1;
            hidx_q <= ridx_q[AW-1:0];
          end
          if (!rd_e.valid && !invf_q) begin
            invf_q <= 1'b1;
            iidx_q <= ridx_q[AW-1:0];
          end
          if ((ridx_q == '0) || (rd_e.stamp < min_q)) begin
            min_q  <= rd_e.stamp;
            midx_q <= ridx_q[AW-1:0];
          end
        end
      end
      S_DEC: begin
        ev_q <= !hitf_q && !invf_q;
        if (hitf_q) begin
          vict_q <= hidx_q;
        end else if (invf_q) begin
          vict_q <= iidx_q;
        end else if (ways_q == CW'(1)) begin
          vict_q <= '0;
        end else begin
          vict_q <= midx_q;
        end
      end
      S_D3: begin
        if (div_res.done) vict_q <= div_res.rem[AW-1:0];
      end
      S_WB: begin
        evtag_q <= ev_q ? rd_e.tag : '0;
      end
      default: ;
    endcase
    if (out_load) begin
      hit_q  <= hitf_q;
      evo_q  <= ev_q;
      evto_q <= evtag_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evo_q;
  assign evicted_tag_o = evto_q;

endmodule

/* rtl/core/cts_checker.sv */
// Port-level checker for the cache tag store, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cts_checker import cts_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input logic          hit_o,
  input logic          evicted_o,
  input logic [TW-1:0] evicted_tag_o
);

  `CTS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `CTS_ASSERT_NXT(a_one_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "request taken while busy")
  `CTS_ASSERT_IMP(a_tag_zero, clk_i, rst_ni, out_valid_o && !evicted_o, evicted_tag_o == '0, "evicted tag without eviction")
  `CTS_ASSERT_IMP(a_hit_noev, clk_i, rst_ni, out_valid_o && hit_o, !evicted_o, "eviction on a hit")

endmodule

bind cache_tag_store_replacement cts_checker u_cts_checker (.*);
